// ===== design/vhkd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vhkd_pkg
// Shared types and constants for the Verlet half kick and drift block.
// ---------------------------------------------------------------------------
package vhkd_pkg;

    localparam int NUM_AXES = 3;
    localparam int DT_FRAC  = 16;

    // configuration register indexes
    localparam logic CFG_TIME_STEP = 1'b0;
    localparam logic CFG_AXIS_MASK = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic        [31:0] mass;
        logic               is_fixed;
        logic               last_in_batch;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic        [31:0] max_move;
        logic               batch_done;
    } t_out_beat;

    typedef struct packed {
        logic        start;
        logic        pin;
        logic [15:0] dt;
    } t_lane_ctl;

    typedef struct packed {
        logic done;
    } t_lane_stat;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_PROD,
        LS_DIV,
        LS_KICK,
        LS_DRIFT,
        LS_POS
    } t_lane_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LANE,
        ST_SUM,
        ST_MAX,
        ST_ROOT,
        ST_PUSH
    } t_top_st;

endpackage
`default_nettype wire

// ===== design/vhkd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vhkd_lane
// One axis: half kick through a bit-serial divider, drift, saturation and
// the squared drift length.
// ---------------------------------------------------------------------------
module vhkd_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire vhkd_pkg::t_lane_ctl i_ctl,
    input  wire signed [31:0]       i_pos,
    input  wire signed [31:0]       i_vel,
    input  wire signed [31:0]       i_force,
    input  wire        [31:0]       i_mass,
    output vhkd_pkg::t_lane_stat    o_stat,
    output logic signed [31:0]      o_pos,
    output logic signed [31:0]      o_vel,
    output logic [63:0]             o_sq
);

    localparam int SHL   = (FRAC_BITS >= 17) ? FRAC_BITS - 17 : 0;
    localparam int SHR   = (FRAC_BITS < 17) ? 17 - FRAC_BITS : 0;
    localparam int NUM_W = 47 + SHL;
    localparam int DEN_W = 32 + SHR;
    localparam int SUM_W = NUM_W + 2;
    localparam int CNT_W = $clog2(NUM_W + 1);

    vhkd_pkg::t_lane_st r_state, n_state;

    logic signed [31:0] r_pos, r_vel_in, r_force;
    logic [31:0]        r_mass;
    logic [15:0]        r_dt;
    logic               r_pin;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den, r_rem;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [31:0] r_vel;
    logic [31:0]        r_dmag;
    logic               r_dneg;
    logic signed [31:0] r_pos_out;
    logic [63:0]        r_sq;

    logic signed [48:0] w_prod;
    logic [48:0]        w_pmag;
    logic [31:0]        w_mass_nz;
    logic [DEN_W:0]     w_rem_sh;
    logic               w_ge;
    logic signed [SUM_W-1:0] w_dq, w_vsum;
    logic signed [31:0] w_vsat;
    logic [31:0]        w_vmag;
    logic [47:0]        w_dprod;
    logic signed [33:0] w_psum;
    logic signed [32:0] w_d;
    logic signed [31:0] w_psat;

    // force times dt and its magnitude
    assign w_prod    = $signed(r_force) * $signed({1'b0, r_dt});
    assign w_pmag    = w_prod[48] ? 49'(-w_prod) : 49'(w_prod);
    assign w_mass_nz = (r_mass == 32'd0) ? 32'd1 : r_mass;

    // one restoring division step
    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    // velocity plus kick, saturated
    assign w_dq   = r_neg ? -$signed(SUM_W'(r_num)) : $signed(SUM_W'(r_num));
    assign w_vsum = SUM_W'(r_vel_in) + w_dq;
    always_comb begin
        if (w_vsum[SUM_W-1:31] == {(SUM_W-31){w_vsum[31]}}) begin
            w_vsat = w_vsum[31:0];
        end else begin
            w_vsat = w_vsum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    // drift magnitude
    assign w_vmag  = r_vel[31] ? 32'(-r_vel) : 32'(r_vel);
    assign w_dprod = w_vmag * r_dt;

    // new position, saturated
    assign w_d    = r_dneg ? -$signed({1'b0, r_dmag}) : $signed({1'b0, r_dmag});
    assign w_psum = 34'(r_pos) + 34'(w_d);
    always_comb begin
        if (w_psum[33:31] == {3{w_psum[31]}}) begin
            w_psat = w_psum[31:0];
        end else begin
            w_psat = w_psum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vhkd_pkg::LS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vhkd_pkg::LS_IDLE:  if (i_ctl.start) n_state = vhkd_pkg::LS_PROD;
            vhkd_pkg::LS_PROD:  n_state = vhkd_pkg::LS_DIV;
            vhkd_pkg::LS_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) n_state = vhkd_pkg::LS_KICK;
            end
            vhkd_pkg::LS_KICK:  n_state = vhkd_pkg::LS_DRIFT;
            vhkd_pkg::LS_DRIFT: n_state = vhkd_pkg::LS_POS;
            vhkd_pkg::LS_POS:   n_state = vhkd_pkg::LS_IDLE;
            default:            n_state = vhkd_pkg::LS_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            vhkd_pkg::LS_IDLE: begin
                if (i_ctl.start) begin
                    r_pos    <= i_pos;
                    r_vel_in <= i_vel;
                    r_force  <= i_force;
                    r_mass   <= i_mass;
                    r_dt     <= i_ctl.dt;
                    r_pin    <= i_ctl.pin;
                end
            end
            vhkd_pkg::LS_PROD: begin
                r_num <= NUM_W'(w_pmag[46:0]) << SHL;
                r_den <= DEN_W'(w_mass_nz) << SHR;
                r_neg <= w_prod[48];
                r_rem <= '0;
                r_cnt <= '0;
            end
            vhkd_pkg::LS_DIV: begin
                r_rem <= w_ge ? DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            vhkd_pkg::LS_KICK: begin
                r_vel <= r_pin ? 32'sd0 : w_vsat;
            end
            vhkd_pkg::LS_DRIFT: begin
                r_dmag <= w_dprod[47:vhkd_pkg::DT_FRAC];
                r_dneg <= r_vel[31];
            end
            vhkd_pkg::LS_POS: begin
                r_pos_out <= w_psat;
                r_sq      <= r_dmag * r_dmag;
            end
            default: ;
        endcase
    end

    assign o_stat.done = (r_state == vhkd_pkg::LS_POS);
    assign o_pos       = r_pos_out;
    assign o_vel       = r_vel;
    assign o_sq        = r_sq;

endmodule
`default_nettype wire

// ===== design/vhkd_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vhkd_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module vhkd_isqrt (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [63:0] r_x, r_res, r_bit;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    // busy flag and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 5'd31) r_busy <= 1'b0;
        end
    end

    // one digit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_value;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_x >= w_trial) begin
                r_x   <= r_x - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd31);
    assign o_root = r_res[31:0];

endmodule
`default_nettype wire

// ===== design/verlet_half_kick_drift_with_fix_mask.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// verlet_half_kick_drift_with_fix_mask
// Velocity Verlet first half step for one particle per beat, three axis
// lanes with per-axis pinning, batch maximum drift and its square root.
// ---------------------------------------------------------------------------
// The lane divider produces one quotient bit a cycle over 47 + max(FRAC_BITS
// - 17, 0) bits; a batch's last beat also runs the one-bit-a-cycle square root.
// One particle is in flight at a time: the input stalls from the accepted beat
// until its result is pushed, which waits while a held result is stalled; a new
// beat is taken while the previous result still waits in the output register.
// Reset clears the configuration registers and the batch maximum.
module verlet_half_kick_drift_with_fix_mask #(
    parameter int FRAC_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire vhkd_pkg::t_in_beat i_in_beat,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output vhkd_pkg::t_out_beat  o_out_beat,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire  [15:0]          i_cfg_wdata
);

    vhkd_pkg::t_top_st r_state, n_state;

    logic [15:0] r_time_step;
    logic [2:0]  r_axis_free_mask;
    logic [63:0] r_max;
    logic        r_last;
    logic [63:0] r_sum;
    logic        r_out_valid;
    vhkd_pkg::t_out_beat r_out;

    logic                 w_accept;
    logic                 w_root_start;
    logic                 w_root_done;
    logic [31:0]          w_root;
    logic [63:0]          w_new_max;
    logic                 w_push;

    logic signed [31:0]   w_pos_in   [vhkd_pkg::NUM_AXES];
    logic signed [31:0]   w_vel_in   [vhkd_pkg::NUM_AXES];
    logic signed [31:0]   w_force_in [vhkd_pkg::NUM_AXES];
    logic signed [31:0]   w_pos_out  [vhkd_pkg::NUM_AXES];
    logic signed [31:0]   w_vel_out  [vhkd_pkg::NUM_AXES];
    logic [63:0]          w_sq       [vhkd_pkg::NUM_AXES];
    vhkd_pkg::t_lane_ctl  w_ctl      [vhkd_pkg::NUM_AXES];
    vhkd_pkg::t_lane_stat w_stat     [vhkd_pkg::NUM_AXES];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != vhkd_pkg::ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step      <= '0;
            r_axis_free_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vhkd_pkg::CFG_TIME_STEP: r_time_step      <= i_cfg_wdata;
                vhkd_pkg::CFG_AXIS_MASK: r_axis_free_mask <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // split the beat per axis
    assign w_pos_in[0]   = i_in_beat.pos_x;
    assign w_pos_in[1]   = i_in_beat.pos_y;
    assign w_pos_in[2]   = i_in_beat.pos_z;
    assign w_vel_in[0]   = i_in_beat.vel_x;
    assign w_vel_in[1]   = i_in_beat.vel_y;
    assign w_vel_in[2]   = i_in_beat.vel_z;
    assign w_force_in[0] = i_in_beat.force_x;
    assign w_force_in[1] = i_in_beat.force_y;
    assign w_force_in[2] = i_in_beat.force_z;

    // axis lanes
    for (genvar a = 0; a < vhkd_pkg::NUM_AXES; a++) begin : g_lane
        assign w_ctl[a].start = w_accept;
        assign w_ctl[a].pin   = i_in_beat.is_fixed && !r_axis_free_mask[a];
        assign w_ctl[a].dt    = r_time_step;

        vhkd_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[a]),
            .i_pos   (w_pos_in[a]),
            .i_vel   (w_vel_in[a]),
            .i_force (w_force_in[a]),
            .i_mass  (i_in_beat.mass),
            .o_stat  (w_stat[a]),
            .o_pos   (w_pos_out[a]),
            .o_vel   (w_vel_out[a]),
            .o_sq    (w_sq[a])
        );
    end

    // batch maximum update
    assign w_new_max    = (r_sum > r_max) ? r_sum : r_max;
    assign w_root_start = (r_state == vhkd_pkg::ST_MAX) && r_last;
    assign w_push       = (r_state == vhkd_pkg::ST_PUSH) && (!r_out_valid || !i_out_stall);

    vhkd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_new_max),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vhkd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vhkd_pkg::ST_IDLE: if (w_accept) n_state = vhkd_pkg::ST_LANE;
            vhkd_pkg::ST_LANE: if (w_stat[0].done) n_state = vhkd_pkg::ST_SUM;
            vhkd_pkg::ST_SUM:  n_state = vhkd_pkg::ST_MAX;
            vhkd_pkg::ST_MAX:  n_state = r_last ? vhkd_pkg::ST_ROOT : vhkd_pkg::ST_PUSH;
            vhkd_pkg::ST_ROOT: if (w_root_done) n_state = vhkd_pkg::ST_PUSH;
            vhkd_pkg::ST_PUSH: if (w_push) n_state = vhkd_pkg::ST_IDLE;
            default:           n_state = vhkd_pkg::ST_IDLE;
        endcase
    end

    // hold last flag, sum squares once the lanes have registered them
    always_ff @(posedge i_clk) begin
        if (w_accept) r_last <= i_in_beat.last_in_batch;
        if (r_state == vhkd_pkg::ST_SUM) r_sum <= w_sq[0] + w_sq[1] + w_sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (r_state == vhkd_pkg::ST_MAX) begin
            r_max <= r_last ? 64'd0 : w_new_max;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out.new_pos_x  <= w_pos_out[0];
            r_out.new_pos_y  <= w_pos_out[1];
            r_out.new_pos_z  <= w_pos_out[2];
            r_out.new_vel_x  <= w_vel_out[0];
            r_out.new_vel_y  <= w_vel_out[1];
            r_out.new_vel_z  <= w_vel_out[2];
            r_out.max_move   <= r_last ? w_root : 32'd0;
            r_out.batch_done <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat[0].done == w_stat[1].done) && (w_stat[0].done == w_stat[2].done))
        else $error("axis lanes out of step");

    // root finishes only while waiting for it
    a_root_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == vhkd_pkg::ST_ROOT))
        else $error("square root done outside root phase");

    // an open batch reports no move
    a_move_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.batch_done) |-> (o_out_beat.max_move == 32'd0))
        else $error("max_move set on a beat that does not close the batch");

    // an accepted beat starts the lanes
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == vhkd_pkg::ST_LANE))
        else $error("accepted beat did not start the lanes");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Verlet half kick and drift block: random and
// directed particles with random stalls, expected beats predicted in-bench.
// ---------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    vhkd_pkg::t_in_beat   in_beat = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    vhkd_pkg::t_out_beat  out_beat;
    logic                 cfg_we = 1'b0;
    logic                 cfg_idx = 1'b0;
    logic [15:0]          cfg_wdata = '0;

    // predictor copy of configuration and batch state
    logic [15:0] dt_q;
    logic [2:0]  free_mask_q;
    logic [63:0] batch_max_sq;

    vhkd_pkg::t_in_beat  particle_q[$];
    vhkd_pkg::t_out_beat expected_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;

    verlet_half_kick_drift_with_fix_mask u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint kick_delta(longint frc, logic [31:0] m);
        longint          prod;
        logic [63:0]     num;
        logic [63:0]     den;
        logic [63:0]     q;
        prod = frc * longint'({48'd0, dt_q});
        num  = (prod < 0) ? -prod : prod;
        den  = (m == 0) ? 64'd1 : {32'd0, m};
        den  = den << 1;
        q    = num / den;
        return (prod < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // predict one result beat and advance the batch maximum
    function automatic vhkd_pkg::t_out_beat predict_step(vhkd_pkg::t_in_beat p);
        vhkd_pkg::t_out_beat r;
        logic [63:0] sq;
        logic [63:0] root;
        longint      pos [3];
        longint      vel [3];
        longint      frc [3];
        longint      d;
        logic [63:0] mag;
        pos = '{p.pos_x, p.pos_y, p.pos_z};
        vel = '{p.vel_x, p.vel_y, p.vel_z};
        frc = '{p.force_x, p.force_y, p.force_z};
        sq = 0;
        for (int a = 0; a < vhkd_pkg::NUM_AXES; a++) begin
            vel[a] = sat_word(vel[a] + kick_delta(frc[a], p.mass));
            mag = (vel[a] < 0) ? -vel[a] : vel[a];
            mag = (mag * {48'd0, dt_q}) >> 16;
            d = (vel[a] < 0) ? -longint'(mag) : longint'(mag);
            if (p.is_fixed && !free_mask_q[a]) begin
                d = 0;
                vel[a] = 0;
            end
            pos[a] = sat_word(pos[a] + d);
            mag = (d < 0) ? -d : d;
            sq += mag * mag;
        end
        r.new_pos_x = pos[0][31:0];
        r.new_pos_y = pos[1][31:0];
        r.new_pos_z = pos[2][31:0];
        r.new_vel_x = vel[0][31:0];
        r.new_vel_y = vel[1][31:0];
        r.new_vel_z = vel[2][31:0];
        if (sq > batch_max_sq) batch_max_sq = sq;
        if (p.last_in_batch) begin
            root         = floor_root(batch_max_sq);
            r.max_move   = root[31:0];
            r.batch_done = 1'b1;
            batch_max_sq = 0;
        end else begin
            r.max_move   = '0;
            r.batch_done = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // drive input beats from the pending queue
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            expected_q.push_back(predict_step(in_beat));
        end
        if (!in_valid || !in_stall) begin
            if (in_valid && !in_stall) in_gap = pick_gap();
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (particle_q.size() > 0 && rst_n) begin
                in_beat  <= particle_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // check result beats and toggle stall
    always @(posedge clk) begin
        vhkd_pkg::t_out_beat w;
        if (out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", out_beat.new_pos_x, '0);
            end else begin
                w = expected_q.pop_front();
                if (out_beat.new_pos_x != w.new_pos_x)
                    report_mismatch("new_pos_x", out_beat.new_pos_x, w.new_pos_x);
                if (out_beat.new_pos_y != w.new_pos_y)
                    report_mismatch("new_pos_y", out_beat.new_pos_y, w.new_pos_y);
                if (out_beat.new_pos_z != w.new_pos_z)
                    report_mismatch("new_pos_z", out_beat.new_pos_z, w.new_pos_z);
                if (out_beat.new_vel_x != w.new_vel_x)
                    report_mismatch("new_vel_x", out_beat.new_vel_x, w.new_vel_x);
                if (out_beat.new_vel_y != w.new_vel_y)
                    report_mismatch("new_vel_y", out_beat.new_vel_y, w.new_vel_y);
                if (out_beat.new_vel_z != w.new_vel_z)
                    report_mismatch("new_vel_z", out_beat.new_vel_z, w.new_vel_z);
                if (out_beat.max_move != w.max_move)
                    report_mismatch("max_move", out_beat.max_move, w.max_move);
                if (out_beat.batch_done != w.batch_done)
                    report_mismatch("batch_done", {31'd0, out_beat.batch_done},
                                    {31'd0, w.batch_done});
            end
        end
        if (out_gap > 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) out_gap = pick_gap();
        end
    end

    // watchdog on accepted beats
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 255) - 128;
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic vhkd_pkg::t_in_beat rand_particle(bit last);
        vhkd_pkg::t_in_beat p;
        p.pos_x = rand_word(); p.pos_y = rand_word(); p.pos_z = rand_word();
        p.vel_x = rand_word(); p.vel_y = rand_word(); p.vel_z = rand_word();
        p.force_x = rand_word(); p.force_y = rand_word(); p.force_z = rand_word();
        case ($urandom_range(0, 4))
            0: p.mass = 32'd0;
            1: p.mass = $urandom_range(1, 16);
            2: p.mass = 32'hFFFFFFFF;
            default: p.mass = $urandom;
        endcase
        p.is_fixed      = $urandom_range(0, 2) == 0;
        p.last_in_batch = last;
        return p;
    endfunction

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == vhkd_pkg::CFG_TIME_STEP) dt_q = val;
        else free_mask_q = val[2:0];
    endtask

    // let the pipeline drain before the next register write
    task automatic wait_idle();
        while (particle_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_batches(int count);
        for (int i = 0; i < count; i++)
            particle_q.push_back(rand_particle($urandom_range(0, 7) == 0 || i == count - 1));
    endtask

    initial begin
        vhkd_pkg::t_in_beat p;
        dt_q = 0;
        free_mask_q = 0;
        batch_max_sq = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero mass, overflowing positions, pinned axes
        write_reg(vhkd_pkg::CFG_TIME_STEP, 16'hFFFF);
        write_reg(vhkd_pkg::CFG_AXIS_MASK, 16'h0005);
        p = '0;
        p.mass = 32'd0;
        p.force_x = 32'sh7FFFFFFF; p.force_y = 32'sh80000000; p.force_z = 32'sd1;
        particle_q.push_back(p);
        p.pos_x = 32'sh7FFFFFF0; p.vel_x = 32'sh7FFFFFFF;
        p.pos_y = 32'sh80000010; p.vel_y = 32'sh80000000;
        p.mass = 32'hFFFFFFFF;
        particle_q.push_back(p);
        p.is_fixed = 1'b1;
        particle_q.push_back(p);
        p.last_in_batch = 1'b1;
        particle_q.push_back(p);
        p = '1;
        particle_q.push_back(p);
        for (int i = 0; i < 15; i++) particle_q.push_back(rand_particle(i % 5 == 4));
        wait_idle();

        // random phases across register settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: write_reg(vhkd_pkg::CFG_TIME_STEP, 16'd0);
                1: write_reg(vhkd_pkg::CFG_TIME_STEP, 16'd1);
                default: write_reg(vhkd_pkg::CFG_TIME_STEP, 16'($urandom_range(0, 65535)));
            endcase
            write_reg(vhkd_pkg::CFG_AXIS_MASK, (ph < 8) ? {13'd0, ph[2:0]} : 16'd7);
            run_batches(200);
            wait_idle();
        end

        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== verlet_half_kick_drift_with_fix_mask.f =====
design/vhkd_pkg.sv
design/vhkd_lane.sv
design/vhkd_isqrt.sv
design/verlet_half_kick_drift_with_fix_mask.sv
tb/sv/tb.sv
